>>> design/bmp_rle8_to_rgb565_decoder_top_macros.svh
`ifndef BMP_RLE8_TO_RGB565_DECODER_TOP_MACROS_SVH
`define BMP_RLE8_TO_RGB565_DECODER_TOP_MACROS_SVH

// Checks that a condition implies another in the same cycle.
`define BMP_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Checks that a condition implies another in the next cycle.
`define BMP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/bmp_pkg.sv
`timescale 1ns / 1ps
package bmp_pkg;

  localparam int SCREEN_WIDTH  = 320;
  localparam int SCREEN_HEIGHT = 240;
  localparam int PALETTE_DEPTH = 256;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = 2;
  localparam int DIV_STEPS     = 17;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_DATA  = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_FORMAT = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE  = 2'd2;

  localparam logic [7:0] BPP_RLE8  = 8'd8;
  localparam logic [7:0] COMP_RLE8 = 8'd1;
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOI   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [2:0] CFG_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_ORG_X  = 3'd2;
  localparam logic [2:0] CFG_ORG_Y  = 3'd3;
  localparam logic [2:0] CFG_BPP    = 3'd4;
  localparam logic [2:0] CFG_COMP   = 3'd5;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] palette_index;
    logic [7:0] red_level;
    logic [7:0] green_level;
    logic [7:0] blue_level;
    logic [7:0] code_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [1:0]  status;
    logic [8:0]  col_first;
    logic [8:0]  col_final;
    logic [7:0]  row_first;
    logic [7:0]  row_final;
    logic [15:0] pixel_color;
    logic [16:0] run_length;
    logic        image_end;
  } out_item_t;

  typedef struct packed {
    logic [8:0] width;
    logic [7:0] height;
    logic [8:0] org_x;
    logic [7:0] org_y;
    logic [7:0] bpp;
    logic [7:0] comp;
  } cfg_t;

  typedef enum logic [1:0] {CLS_LOAD, CLS_START, CLS_DATA} cls_t;

  typedef struct packed {
    cls_t        cls;
    logic [7:0]  index;
    logic [15:0] color;
    logic [7:0]  code;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

  typedef enum logic [2:0] {
    PH_IDLE, PH_FIRST, PH_SECOND, PH_DX, PH_DY, PH_ABS, PH_PAD
  } phase_t;

  typedef enum logic [2:0] {B_FETCH, B_EXEC, B_MUL, B_DIV_Q, B_DIV_R} bstate_t;

  function automatic logic [15:0] to_rgb565(input logic [7:0] r, input logic [7:0] g,
                                            input logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

endpackage

>>> design/bmp_ram.sv
`timescale 1ns / 1ps
module bmp_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;
endmodule

>>> design/bmp_div.sv
`timescale 1ns / 1ps
module bmp_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [16:0] dividend,
  input  logic [8:0]  divisor,
  output logic        done,
  output logic [16:0] quotient,
  output logic [8:0]  remainder
);
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [8:0]  rem_r, rem_nxt;
  logic [16:0] quo_r, quo_nxt;
  logic [8:0]  dvs_r, dvs_nxt;
  logic [9:0]  trial;

  always_comb begin
    trial    = {rem_r, quo_r[16]};
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      cnt_nxt  = 5'(bmp_pkg::DIV_STEPS);
      busy_nxt = 1'b1;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = 9'(trial - {1'b0, dvs_r});
        quo_nxt = {quo_r[15:0], 1'b1};
      end else begin
        rem_nxt = trial[8:0];
        quo_nxt = {quo_r[15:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;
endmodule

>>> design/bmp_front.sv
`timescale 1ns / 1ps
module bmp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmp_pkg::in_item_t  in_data,
  output bmp_pkg::q_head_t   head,
  input  logic               pop
);
  bmp_pkg::cmd_t                q_r [bmp_pkg::QUEUE_DEPTH];
  logic [bmp_pkg::QUEUE_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [bmp_pkg::QUEUE_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [bmp_pkg::QUEUE_AW:0]   count_r, count_nxt;
  logic                         push;
  bmp_pkg::cmd_t                cmd;

  always_comb begin
    cmd.index = in_data.palette_index;
    cmd.color = bmp_pkg::to_rgb565(in_data.red_level, in_data.green_level,
                                   in_data.blue_level);
    cmd.code  = in_data.code_byte;
    case (in_data.func)
      bmp_pkg::FUNC_LOAD:  cmd.cls = bmp_pkg::CLS_LOAD;
      bmp_pkg::FUNC_START: cmd.cls = bmp_pkg::CLS_START;
      default:             cmd.cls = bmp_pkg::CLS_DATA;
    endcase
  end

  assign in_ready = count_r != (bmp_pkg::QUEUE_AW + 1)'(bmp_pkg::QUEUE_DEPTH);
  // An unused function code is taken and dropped here.
  assign push = in_valid && in_ready && (in_data.func != 2'd3);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (bmp_pkg::QUEUE_AW + 1)'(push) - (bmp_pkg::QUEUE_AW + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

  assign head.valid = count_r != '0;
  assign head.cmd   = q_r[rd_ptr_r];
endmodule

>>> design/bmp_back.sv
`timescale 1ns / 1ps
`include "bmp_rle8_to_rgb565_decoder_top_macros.svh"
module bmp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  bmp_pkg::q_head_t   head,
  output logic               pop,
  input  bmp_pkg::cfg_t      cfg,
  output logic               out_valid,
  input  logic               out_ready,
  output bmp_pkg::out_item_t out_data
);
  bmp_pkg::bstate_t   state_r, state_nxt;
  bmp_pkg::phase_t    phase_r, phase_nxt;
  logic [7:0]         pending_r, pending_nxt;
  logic [7:0]         abs_left_r, abs_left_nxt;
  logic               pad_r, pad_nxt;
  logic [7:0]         delta_r, delta_nxt;
  logic [8:0]         col_r, col_nxt;
  logic [7:0]         row_r, row_nxt;
  bmp_pkg::cmd_t      item_r;
  logic [15:0]        color_r, color_nxt;
  logic [16:0]        mul_r, mul_nxt;
  logic [8:0]         base_r, base_nxt;
  logic               eoi_r, eoi_nxt;
  logic [16:0]        len_r, len_nxt;
  logic               out_valid_r, out_valid_nxt;
  bmp_pkg::out_item_t out_data_r, out_data_nxt;

  logic [15:0] pal_q;
  logic [7:0]  rd_addr;
  logic        pal_we;
  logic        div_start, div_done;
  logic [16:0] div_dividend, div_quo;
  logic [8:0]  div_rem;

  logic        is_data, is_eoi, is_dy;
  logic [9:0]  col_pend, col_one;
  logic [8:0]  line_rest;
  logic [7:0]  rows_left;
  logic [7:0]  mul_a;
  logic [16:0] len_sum;
  logic [17:0] col_len, row_q;
  logic [1:0]  st;
  logic [9:0]  x_end;
  logic [8:0]  y_end;
  logic [7:0]  rf;
  logic [7:0]  abs_dec;

  assign pop = (state_r == bmp_pkg::B_FETCH) && head.valid && !out_valid_r;
  assign pal_we = pop && (head.cmd.cls == bmp_pkg::CLS_LOAD);

  always_comb begin
    rd_addr = '0;
    if (head.cmd.cls == bmp_pkg::CLS_DATA &&
        ((phase_r == bmp_pkg::PH_SECOND && pending_r != '0) || phase_r == bmp_pkg::PH_ABS)) begin
      rd_addr = head.cmd.code;
    end
  end

  bmp_ram #(.WIDTH(16), .DEPTH(bmp_pkg::PALETTE_DEPTH)) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (head.cmd.index),
    .wdata (head.cmd.color),
    .re    (pop),
    .raddr (rd_addr),
    .rdata (pal_q)
  );

  bmp_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (cfg.width),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  always_comb begin
    is_data   = item_r.cls == bmp_pkg::CLS_DATA;
    is_eoi    = is_data && phase_r == bmp_pkg::PH_SECOND && pending_r == '0 &&
                item_r.code == bmp_pkg::ESC_EOI;
    is_dy     = is_data && phase_r == bmp_pkg::PH_DY;
    col_pend  = {1'b0, col_r} + {2'b0, pending_r};
    col_one   = {1'b0, col_r} + 10'd1;
    line_rest = (col_r >= cfg.width) ? 9'd0 : cfg.width - col_r;
    rows_left = ({1'b0, row_r} + 9'd1 >= {1'b0, cfg.height}) ? 8'd0
                : cfg.height - row_r - 8'd1;
    mul_a     = is_eoi ? rows_left : item_r.code;
    len_sum   = {8'b0, base_r} + mul_r;
    col_len   = {9'b0, col_r} + {1'b0, len_r};
    row_q     = {10'b0, row_r} + {1'b0, div_quo};
    x_end     = {1'b0, cfg.org_x} + {1'b0, cfg.width};
    y_end     = {1'b0, cfg.org_y} + {1'b0, cfg.height};
    rf        = 8'(bmp_pkg::SCREEN_HEIGHT) - cfg.org_y - cfg.height;
    abs_dec   = abs_left_r - 8'd1;
    if (cfg.bpp != bmp_pkg::BPP_RLE8 || cfg.comp != bmp_pkg::COMP_RLE8) begin
      st = bmp_pkg::ST_BAD_FORMAT;
    end else if (cfg.width == '0 || cfg.height == '0 ||
                 x_end > 10'(bmp_pkg::SCREEN_WIDTH) ||
                 y_end > 9'(bmp_pkg::SCREEN_HEIGHT)) begin
      st = bmp_pkg::ST_TOO_LARGE;
    end else begin
      st = bmp_pkg::ST_OK;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bmp_pkg::B_FETCH: begin
        if (pop && head.cmd.cls != bmp_pkg::CLS_LOAD) state_nxt = bmp_pkg::B_EXEC;
      end
      bmp_pkg::B_EXEC: begin
        state_nxt = (is_eoi || is_dy) ? bmp_pkg::B_MUL : bmp_pkg::B_FETCH;
      end
      bmp_pkg::B_MUL: begin
        state_nxt = (!eoi_r && cfg.width != '0) ? bmp_pkg::B_DIV_Q : bmp_pkg::B_FETCH;
      end
      bmp_pkg::B_DIV_Q: begin
        if (div_done) state_nxt = bmp_pkg::B_DIV_R;
      end
      bmp_pkg::B_DIV_R: begin
        if (div_done) state_nxt = bmp_pkg::B_FETCH;
      end
      default: state_nxt = bmp_pkg::B_FETCH;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    phase_nxt     = phase_r;
    pending_nxt   = pending_r;
    abs_left_nxt  = abs_left_r;
    pad_nxt       = pad_r;
    delta_nxt     = delta_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    color_nxt     = color_r;
    mul_nxt       = mul_r;
    base_nxt      = base_r;
    eoi_nxt       = eoi_r;
    len_nxt       = len_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;
    div_dividend  = len_r;
    case (state_r)
      bmp_pkg::B_EXEC: begin
        out_data_nxt      = '0;
        out_data_nxt.kind = 1'b1;
        if (item_r.cls == bmp_pkg::CLS_START) begin
          out_data_nxt.kind   = 1'b0;
          out_data_nxt.status = st;
          out_valid_nxt       = 1'b1;
          if (st == bmp_pkg::ST_OK) begin
            out_data_nxt.col_first = cfg.org_x;
            out_data_nxt.col_final = 9'(x_end - 10'd1);
            out_data_nxt.row_first = rf;
            out_data_nxt.row_final = rf + cfg.height - 8'd1;
            phase_nxt = bmp_pkg::PH_FIRST;
          end else begin
            phase_nxt = bmp_pkg::PH_IDLE;
          end
          pending_nxt  = '0;
          abs_left_nxt = '0;
          pad_nxt      = 1'b0;
          delta_nxt    = '0;
          col_nxt      = '0;
          row_nxt      = '0;
        end else begin
          color_nxt = pal_q;
          mul_nxt   = 17'({9'b0, mul_a} * {8'b0, cfg.width});
          eoi_nxt   = is_eoi;
          base_nxt  = is_eoi ? line_rest : {1'b0, delta_r};
          case (phase_r)
            bmp_pkg::PH_FIRST: begin
              pending_nxt = item_r.code;
              phase_nxt   = bmp_pkg::PH_SECOND;
            end
            bmp_pkg::PH_SECOND: begin
              if (pending_r != '0) begin
                col_nxt = col_pend[9] ? 9'd511 : col_pend[8:0];
                out_data_nxt.pixel_color = pal_q;
                out_data_nxt.run_length  = {9'b0, pending_r};
                out_valid_nxt = 1'b1;
                phase_nxt     = bmp_pkg::PH_FIRST;
              end else if (item_r.code == bmp_pkg::ESC_EOL) begin
                col_nxt = '0;
                row_nxt = (row_r == 8'd255) ? row_r : row_r + 8'd1;
                out_data_nxt.pixel_color = pal_q;
                out_data_nxt.run_length  = {8'b0, line_rest};
                out_valid_nxt = 1'b1;
                phase_nxt     = bmp_pkg::PH_FIRST;
              end else if (item_r.code == bmp_pkg::ESC_EOI) begin
                phase_nxt = bmp_pkg::PH_SECOND;
              end else if (item_r.code == bmp_pkg::ESC_DELTA) begin
                phase_nxt = bmp_pkg::PH_DX;
              end else begin
                abs_left_nxt = item_r.code;
                pad_nxt      = item_r.code[0];
                phase_nxt    = bmp_pkg::PH_ABS;
              end
            end
            bmp_pkg::PH_DX: begin
              delta_nxt = item_r.code;
              phase_nxt = bmp_pkg::PH_DY;
            end
            bmp_pkg::PH_ABS: begin
              col_nxt      = col_one[9] ? 9'd511 : col_one[8:0];
              abs_left_nxt = abs_dec;
              if (abs_dec == '0) begin
                phase_nxt = pad_r ? bmp_pkg::PH_PAD : bmp_pkg::PH_FIRST;
              end
              out_data_nxt.pixel_color = pal_q;
              out_data_nxt.run_length  = 17'd1;
              out_valid_nxt = 1'b1;
            end
            bmp_pkg::PH_PAD: begin
              pad_nxt   = 1'b0;
              phase_nxt = bmp_pkg::PH_FIRST;
            end
            default: phase_nxt = phase_r;
          endcase
        end
      end
      bmp_pkg::B_MUL: begin
        len_nxt = len_sum;
        out_data_nxt             = '0;
        out_data_nxt.kind        = 1'b1;
        out_data_nxt.pixel_color = color_r;
        out_data_nxt.run_length  = len_sum;
        if (eoi_r) begin
          out_data_nxt.image_end = 1'b1;
          out_valid_nxt = 1'b1;
          phase_nxt     = bmp_pkg::PH_IDLE;
        end else if (cfg.width == '0) begin
          col_nxt = ({9'b0, col_r} + {1'b0, len_sum} > 18'd511) ? 9'd511
                    : 9'({9'b0, col_r} + {1'b0, len_sum});
          out_valid_nxt = 1'b1;
          phase_nxt     = bmp_pkg::PH_FIRST;
        end else begin
          div_start    = 1'b1;
          div_dividend = len_sum;
        end
      end
      bmp_pkg::B_DIV_Q: begin
        if (div_done) begin
          row_nxt      = (row_q > 18'd255) ? 8'd255 : row_q[7:0];
          div_start    = 1'b1;
          div_dividend = col_len[16:0];
        end
      end
      bmp_pkg::B_DIV_R: begin
        if (div_done) begin
          col_nxt       = div_rem;
          out_valid_nxt = 1'b1;
          phase_nxt     = bmp_pkg::PH_FIRST;
        end
      end
      default: begin
        out_data_nxt = out_data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bmp_pkg::B_FETCH;
      phase_r     <= bmp_pkg::PH_IDLE;
      pending_r   <= '0;
      abs_left_r  <= '0;
      pad_r       <= 1'b0;
      delta_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      pending_r   <= pending_nxt;
      abs_left_r  <= abs_left_nxt;
      pad_r       <= pad_nxt;
      delta_r     <= delta_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (pop) begin
      item_r <= head.cmd;
    end
    color_r    <= color_nxt;
    mul_r      <= mul_nxt;
    base_r     <= base_nxt;
    eoi_r      <= eoi_nxt;
    len_r      <= len_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BMP_ASSERT_SAME(a_busy_no_result, state_r != bmp_pkg::B_FETCH, !out_valid_r)
  `BMP_ASSERT_SAME(a_div_start_state, div_start, state_r == bmp_pkg::B_MUL || state_r == bmp_pkg::B_DIV_Q)
  `BMP_ASSERT_SAME(a_abs_count_live, phase_r == bmp_pkg::PH_ABS, abs_left_r != '0)
  `BMP_ASSERT_NEXT(a_pop_to_exec, pop && head.cmd.cls != bmp_pkg::CLS_LOAD, state_r == bmp_pkg::B_EXEC)
endmodule

>>> design/bmp_rle8_to_rgb565_decoder_top.sv
`timescale 1ns / 1ps
// RLE8 bitmap decoder with RGB565 run output. Items enter a four-entry queue and
// are executed one at a time by the back end. A palette load is written as it
// is taken from the queue, a start item or an ordinary data byte takes a palette
// memory read plus execute, an end-of-image code adds one multiply stage, and a
// delta code adds the multiply stage and two passes through the 17-step serial
// divider. A new item is taken from the queue only once the previous result has
// been transferred. Configuration registers sit at byte addresses 0 to 20 and
// read back the stored field bits, with the upper bits as zero.
module bmp_rle8_to_rgb565_decoder_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bmp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bmp_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  bmp_pkg::cfg_t    cfg_r, cfg_nxt;
  bmp_pkg::q_head_t head;
  logic             pop;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (paddr[4:2])
        bmp_pkg::CFG_WIDTH:  cfg_nxt.width  = pwdata[8:0];
        bmp_pkg::CFG_HEIGHT: cfg_nxt.height = pwdata[7:0];
        bmp_pkg::CFG_ORG_X:  cfg_nxt.org_x  = pwdata[8:0];
        bmp_pkg::CFG_ORG_Y:  cfg_nxt.org_y  = pwdata[7:0];
        bmp_pkg::CFG_BPP:    cfg_nxt.bpp    = pwdata[7:0];
        bmp_pkg::CFG_COMP:   cfg_nxt.comp   = pwdata[7:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      bmp_pkg::CFG_WIDTH:  prdata = {23'b0, cfg_r.width};
      bmp_pkg::CFG_HEIGHT: prdata = {24'b0, cfg_r.height};
      bmp_pkg::CFG_ORG_X:  prdata = {23'b0, cfg_r.org_x};
      bmp_pkg::CFG_ORG_Y:  prdata = {24'b0, cfg_r.org_y};
      bmp_pkg::CFG_BPP:    prdata = {24'b0, cfg_r.bpp};
      bmp_pkg::CFG_COMP:   prdata = {24'b0, cfg_r.comp};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.width  <= 9'd1;
      cfg_r.height <= 8'd1;
      cfg_r.org_x  <= '0;
      cfg_r.org_y  <= '0;
      cfg_r.bpp    <= bmp_pkg::BPP_RLE8;
      cfg_r.comp   <= bmp_pkg::COMP_RLE8;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  bmp_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  bmp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg       (cfg_r),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );
endmodule
